// File: design/line_follower_pid_drive_core_macros.svh
// assertion helpers used by the checker
`ifndef LINE_FOLLOWER_PID_DRIVE_CORE_MACROS_SVH
`define LINE_FOLLOWER_PID_DRIVE_CORE_MACROS_SVH

// property checked only while out of reset
`define LFPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define LFPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/lfpd_pkg.sv
package lfpd_pkg;

    // sensor channels
    localparam int SENSOR_FIELDS = 8;
    localparam int SENSOR_COUNT  = 8;
    localparam int SENSOR_USED   = (SENSOR_COUNT < SENSOR_FIELDS) ? SENSOR_COUNT : SENSOR_FIELDS;
    localparam int CNT_W         = $clog2(SENSOR_FIELDS + 1);

    // port widths
    localparam int POS_W      = 13;
    localparam int SNS_W      = 10;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int TRIM_W     = 8;
    localparam int SPD_W      = 8;
    localparam int THR_W      = 10;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DRV_OUT_W  = 9;
    localparam int MODE_W     = 2;

    // datapath widths
    localparam int ERR_W  = 14;
    localparam int DIFF_W = 15;
    localparam int SUM_W  = 7;
    localparam int FS_W   = 32;
    localparam int OPA_W  = GAIN_W + 1;
    localparam int OPB_W  = 32;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int CTL_W  = ACC_W - 32;
    localparam int DRV_W  = 28;
    localparam int BASE_W = SPD_W + 1;
    localparam int UPC_W  = 4;

    // control law constants
    localparam int CENTER      = 3500;
    localparam int CROSS_LEVEL = 500;
    localparam int CROSS_COUNT = 6;
    localparam int SUM_LIMIT   = 50;
    localparam int FILT_OLD    = 39322;
    localparam int FILT_NEW    = 26214;
    localparam int BAND_NEAR   = 400;
    localparam int BAND_MID    = 1200;
    localparam int BAND_FAR    = 2500;
    localparam int SPEED_BOOST = 30;
    localparam int RECIP_10    = 6554;
    localparam int RECIP_20    = 3277;
    localparam int DRIVE_MAX   = 255;
    localparam int DRIVE_MIN   = -130;
    localparam int SPIN_SPEED  = 140;

    // register reset values
    localparam logic [GAIN_W-1:0] KP_RESET   = 24'd4915;
    localparam logic [GAIN_W-1:0] KI_RESET   = 24'd0;
    localparam logic [GAIN_W-1:0] KD_RESET   = 24'd32768;
    localparam logic [TRIM_W-1:0] TRIM_RESET = 8'd0;
    localparam logic [SPD_W-1:0]  BASE_RESET = 8'd210;
    localparam logic [THR_W-1:0]  THR_RESET  = 10'd250;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP    = 3'd0,
        CFG_KI    = 3'd1,
        CFG_KD    = 3'd2,
        CFG_LTRIM = 3'd3,
        CFG_RTRIM = 3'd4,
        CFG_BASE  = 3'd5,
        CFG_THR   = 3'd6,
        CFG_TMO   = 3'd7
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_FOLLOW = 2'd0,
        MODE_SPIN   = 2'd1,
        MODE_STOP   = 2'd2
    } t_mode;

    // microcode fields
    typedef enum logic [2:0] {
        MA_KP, MA_KI, MA_KD, MA_OLD, MA_NEW
    } t_mul_a;

    typedef enum logic [1:0] {
        MB_E, MB_SUM, MB_FS, MB_D
    } t_mul_b;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD_SHR16, ACC_ADD, ACC_LOAD_SHL16, ACC_ADD_SHL16
    } t_acc_op;

    typedef enum logic [2:0] {
        DP_NOP, DP_LOAD, DP_INTEG, DP_FS_SAVE, DP_CTRL, DP_FIT_HI, DP_EMIT, DP_LOST
    } t_dp_op;

    typedef enum logic [1:0] {
        JC_NEXT, JC_ACCEPT, JC_WAIT_OUT
    } t_jcond;

    typedef logic [UPC_W-1:0] t_upc;

    // program steps
    localparam t_upc ST_IDLE  = 4'd0;
    localparam t_upc ST_INTEG = 4'd1;
    localparam t_upc ST_FILT  = 4'd2;
    localparam t_upc ST_PTERM = 4'd3;
    localparam t_upc ST_ITERM = 4'd4;
    localparam t_upc ST_DTERM = 4'd5;
    localparam t_upc ST_TOTAL = 4'd6;
    localparam t_upc ST_CTRL  = 4'd7;
    localparam t_upc ST_FIT   = 4'd8;
    localparam t_upc ST_EMIT  = 4'd9;
    localparam t_upc ST_LOST  = 4'd10;

    typedef struct packed {
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        t_acc_op acc_op;
        t_dp_op  dp_op;
        t_jcond  cond;
        t_upc    target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic seen;
        logic out_busy;
    } t_seq_stat;

    typedef struct packed {
        t_uword uw;
        logic   go;
    } t_seq_ctl;

    function automatic t_uword uword(t_mul_a ma, t_mul_b mb, t_acc_op ao, t_dp_op dp,
                                     t_jcond jc, t_upc tg);
        t_uword w;
        w.mul_a  = ma;
        w.mul_b  = mb;
        w.acc_op = ao;
        w.dp_op  = dp;
        w.cond   = jc;
        w.target = tg;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode_rom(t_upc step);
        t_uword w;
        unique case (step)
            ST_IDLE:  w = uword(MA_KP,  MB_E,   ACC_HOLD,       DP_LOAD,    JC_ACCEPT,   ST_LOST);
            ST_INTEG: w = uword(MA_OLD, MB_FS,  ACC_HOLD,       DP_INTEG,   JC_NEXT,     ST_IDLE);
            ST_FILT:  w = uword(MA_NEW, MB_D,   ACC_LOAD_SHR16, DP_NOP,     JC_NEXT,     ST_IDLE);
            ST_PTERM: w = uword(MA_KP,  MB_E,   ACC_ADD,        DP_NOP,     JC_NEXT,     ST_IDLE);
            ST_ITERM: w = uword(MA_KI,  MB_SUM, ACC_LOAD_SHL16, DP_FS_SAVE, JC_NEXT,     ST_IDLE);
            ST_DTERM: w = uword(MA_KD,  MB_FS,  ACC_ADD_SHL16,  DP_NOP,     JC_NEXT,     ST_IDLE);
            ST_TOTAL: w = uword(MA_KD,  MB_FS,  ACC_ADD,        DP_NOP,     JC_NEXT,     ST_IDLE);
            ST_CTRL:  w = uword(MA_KP,  MB_E,   ACC_HOLD,       DP_CTRL,    JC_NEXT,     ST_IDLE);
            ST_FIT:   w = uword(MA_KP,  MB_E,   ACC_HOLD,       DP_FIT_HI,  JC_NEXT,     ST_IDLE);
            ST_EMIT:  w = uword(MA_KP,  MB_E,   ACC_HOLD,       DP_EMIT,    JC_WAIT_OUT, ST_IDLE);
            ST_LOST:  w = uword(MA_KP,  MB_E,   ACC_HOLD,       DP_LOST,    JC_WAIT_OUT, ST_IDLE);
            default:  w = uword(MA_KP,  MB_E,   ACC_HOLD,       DP_NOP,     JC_WAIT_OUT, ST_IDLE);
        endcase
        return w;
    endfunction

    // base speed by error band, constant divides as reciprocal multiplies
    function automatic logic [BASE_W-1:0] base_for_error(logic [SPD_W-1:0] speed,
                                                          logic signed [ERR_W-1:0] err);
        logic [ERR_W-1:0] mag;
        logic [10:0]      x7;
        logic [11:0]      x9;
        logic [23:0]      q10;
        logic [23:0]      q20;
        logic [BASE_W-1:0] b;
        mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        x7  = 11'(speed) * 11'd7;
        x9  = 12'(speed) * 12'd9;
        q10 = 24'(x7) * 24'(RECIP_10);
        q20 = 24'(x9) * 24'(RECIP_20);
        if (mag < ERR_W'(BAND_NEAR)) begin
            b = BASE_W'(speed) + BASE_W'(SPEED_BOOST);
        end else if (mag < ERR_W'(BAND_MID)) begin
            b = BASE_W'(speed);
        end else if (mag < ERR_W'(BAND_FAR)) begin
            b = BASE_W'(q10[23:16]);
        end else begin
            b = BASE_W'(q20[23:16]);
        end
        return b;
    endfunction

endpackage

// File: design/lfpd_useq.sv
module lfpd_useq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lfpd_pkg::t_seq_stat   i_stat,
    output lfpd_pkg::t_seq_ctl    o_ctl
);
    import lfpd_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uw;
    logic   w_go;

    // fetch
    assign w_uw = ucode_rom(r_upc);

    // branch and stall decision
    always_comb begin
        n_upc = r_upc;
        w_go  = 1'b0;
        unique case (w_uw.cond)
            JC_NEXT: begin
                w_go  = 1'b1;
                n_upc = t_upc'(r_upc + 1'b1);
            end
            JC_ACCEPT: begin
                w_go = i_stat.in_valid;
                if (i_stat.in_valid) begin
                    n_upc = i_stat.seen ? t_upc'(r_upc + 1'b1) : w_uw.target;
                end
            end
            JC_WAIT_OUT: begin
                w_go = !i_stat.out_busy;
                if (!i_stat.out_busy) begin
                    n_upc = w_uw.target;
                end
            end
            default: begin
                w_go  = 1'b1;
                n_upc = w_uw.target;
            end
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl.uw = w_uw;
    assign o_ctl.go = w_go;

endmodule

// File: design/line_follower_pid_drive_core.sv
// a followed sample is accepted in the idle step, then runs the integrate, filter,
// P, I, D, total, control, fit and emit steps in turn on the shared multiplier;
// a lost-line sample goes from the idle step to the lost step; the emit and lost
// steps write the result word, stalling while the output word is held, and no new
// sample is taken until the idle step; reset (synchronous, active low) restores
// register defaults, clears the control state and the output valid flag; no clearing pass
module line_follower_pid_drive_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [lfpd_pkg::POS_W-1:0]            i_line_position,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_0,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_1,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_2,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_3,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_4,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_5,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_6,
    input  logic [lfpd_pkg::SNS_W-1:0]            i_sensor_7,
    input  logic [lfpd_pkg::TIME_W-1:0]           i_time_ms,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lfpd_pkg::DRV_OUT_W-1:0] o_left_speed,
    output logic signed [lfpd_pkg::DRV_OUT_W-1:0] o_right_speed,
    output logic [lfpd_pkg::MODE_W-1:0]           o_drive_mode,
    output logic                                  o_crossing,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lfpd_pkg::*;

    localparam logic signed [ERR_W-1:0]     CENTER_E = ERR_W'(CENTER);
    localparam logic signed [DIFF_W-1:0]    SUM_HI   = DIFF_W'(SUM_LIMIT);
    localparam logic signed [DIFF_W-1:0]    SUM_LO   = DIFF_W'(-SUM_LIMIT);
    localparam logic signed [DRV_W-1:0]     DRV_HI   = DRV_W'(DRIVE_MAX);
    localparam logic signed [DRV_W-1:0]     DRV_LO   = DRV_W'(DRIVE_MIN);
    localparam logic signed [DRV_OUT_W-1:0] SPIN_POS = DRV_OUT_W'(SPIN_SPEED);
    localparam logic signed [DRV_OUT_W-1:0] SPIN_NEG = -SPIN_POS;
    localparam logic signed [OPA_W-1:0]     OLD_W    = OPA_W'(FILT_OLD);
    localparam logic signed [OPA_W-1:0]     NEW_W    = OPA_W'(FILT_NEW);

    // configuration registers
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic [GAIN_W-1:0]        r_kd;
    logic signed [TRIM_W-1:0] r_ltrim;
    logic signed [TRIM_W-1:0] r_rtrim;
    logic [SPD_W-1:0]         r_base_speed;
    logic [THR_W-1:0]         r_thr;
    logic [TMO_W-1:0]         r_tmo;

    // controller state
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [FS_W-1:0]   r_fs;
    logic                     r_turn;
    logic                     r_lost;
    logic [TIME_W-1:0]        r_since;

    // working registers
    logic signed [ERR_W-1:0]  r_e;
    logic signed [DIFF_W-1:0] r_d;
    logic                     r_cross;
    logic [TIME_W-1:0]        r_time;
    logic [BASE_W-1:0]        r_base;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DRV_W-1:0]  r_l;
    logic signed [DRV_W-1:0]  r_r;

    // output word
    logic                        r_out_valid;
    logic signed [DRV_OUT_W-1:0] r_left;
    logic signed [DRV_OUT_W-1:0] r_right;
    t_mode                       r_mode;

    logic [SNS_W-1:0]         w_sns [SENSOR_FIELDS];
    logic                     w_seen;
    logic [CNT_W-1:0]         w_cnt;
    logic signed [ERR_W-1:0]  w_e_in;
    t_seq_stat                w_stat;
    t_seq_ctl                 w_ctl;
    logic                     w_go;
    t_dp_op                   w_dp;
    logic signed [OPA_W-1:0]  w_opa;
    logic signed [OPB_W-1:0]  w_opb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [DIFF_W-1:0] w_sum_raw;
    logic signed [SUM_W-1:0]  w_sum_new;
    logic signed [FS_W-1:0]   w_fs_sat;
    logic signed [ACC_W-1:0]  w_total;
    logic [ACC_W-1:0]         w_round;
    logic signed [CTL_W-1:0]  w_c;
    logic signed [DRV_W-1:0]  w_max;
    logic signed [DRV_W-1:0]  w_ex_hi;
    logic signed [DRV_W-1:0]  w_min;
    logic signed [DRV_W-1:0]  w_ex_lo;
    logic signed [DRV_W-1:0]  w_l2;
    logic signed [DRV_W-1:0]  w_r2;
    logic signed [DRV_W-1:0]  w_lc;
    logic signed [DRV_W-1:0]  w_rc;
    logic [TIME_W-1:0]        w_since;
    logic [TIME_W-1:0]        w_elapsed;
    logic                     w_over;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= KP_RESET;
            r_ki         <= KI_RESET;
            r_kd         <= KD_RESET;
            r_ltrim      <= TRIM_RESET;
            r_rtrim      <= TRIM_RESET;
            r_base_speed <= BASE_RESET;
            r_thr        <= THR_RESET;
            r_tmo        <= TMO_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KP:    r_kp         <= i_cfg_data[GAIN_W-1:0];
                CFG_KI:    r_ki         <= i_cfg_data[GAIN_W-1:0];
                CFG_KD:    r_kd         <= i_cfg_data[GAIN_W-1:0];
                CFG_LTRIM: r_ltrim      <= i_cfg_data[TRIM_W-1:0];
                CFG_RTRIM: r_rtrim      <= i_cfg_data[TRIM_W-1:0];
                CFG_BASE:  r_base_speed <= i_cfg_data[SPD_W-1:0];
                CFG_THR:   r_thr        <= i_cfg_data[THR_W-1:0];
                CFG_TMO:   r_tmo        <= i_cfg_data[TMO_W-1:0];
                default:   r_kp         <= r_kp;
            endcase
        end
    end

    // sensor scan: line seen and crossing count
    assign w_sns[0] = i_sensor_0;
    assign w_sns[1] = i_sensor_1;
    assign w_sns[2] = i_sensor_2;
    assign w_sns[3] = i_sensor_3;
    assign w_sns[4] = i_sensor_4;
    assign w_sns[5] = i_sensor_5;
    assign w_sns[6] = i_sensor_6;
    assign w_sns[7] = i_sensor_7;

    always_comb begin
        w_seen = 1'b0;
        w_cnt  = '0;
        for (int i = 0; i < SENSOR_USED; i++) begin
            if (w_sns[i] > r_thr) begin
                w_seen = 1'b1;
            end
            if (w_sns[i] > SNS_W'(CROSS_LEVEL)) begin
                w_cnt = w_cnt + CNT_W'(1);
            end
        end
    end

    assign w_e_in = $signed({1'b0, i_line_position}) - CENTER_E;

    // sequencer
    assign w_stat.in_valid = i_in_valid;
    assign w_stat.seen     = w_seen;
    assign w_stat.out_busy = r_out_valid && !i_out_ready;

    lfpd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl)
    );

    assign w_go       = w_ctl.go;
    assign w_dp       = w_ctl.uw.dp_op;
    assign o_in_ready = (w_ctl.uw.cond == JC_ACCEPT);

    // shared multiplier operands
    always_comb begin
        unique case (w_ctl.uw.mul_a)
            MA_KP:   w_opa = $signed({1'b0, r_kp});
            MA_KI:   w_opa = $signed({1'b0, r_ki});
            MA_KD:   w_opa = $signed({1'b0, r_kd});
            MA_OLD:  w_opa = OLD_W;
            MA_NEW:  w_opa = NEW_W;
            default: w_opa = '0;
        endcase
        unique case (w_ctl.uw.mul_b)
            MB_E:    w_opb = OPB_W'(r_e);
            MB_SUM:  w_opb = OPB_W'(r_sum);
            MB_FS:   w_opb = OPB_W'(r_fs);
            MB_D:    w_opb = OPB_W'(r_d);
            default: w_opb = '0;
        endcase
    end

    assign w_prod = w_opa * w_opb;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            unique case (w_ctl.uw.acc_op)
                ACC_HOLD:       r_acc <= r_acc;
                ACC_LOAD_SHR16: r_acc <= ACC_W'(r_prod >>> 16);
                ACC_ADD:        r_acc <= r_acc + ACC_W'(r_prod);
                ACC_LOAD_SHL16: r_acc <= (ACC_W'(r_prod) <<< 16);
                ACC_ADD_SHL16:  r_acc <= r_acc + (ACC_W'(r_prod) <<< 16);
                default:        r_acc <= r_acc;
            endcase
        end
    end

    // integral clamp and filter saturation
    always_comb begin
        w_sum_raw = DIFF_W'(r_sum) + DIFF_W'(r_e);
        if (w_sum_raw > SUM_HI) begin
            w_sum_new = SUM_W'(SUM_HI);
        end else if (w_sum_raw < SUM_LO) begin
            w_sum_new = SUM_W'(SUM_LO);
        end else begin
            w_sum_new = SUM_W'(w_sum_raw);
        end
        if ((&r_acc[ACC_W-1:FS_W-1]) || !(|r_acc[ACC_W-1:FS_W-1])) begin
            w_fs_sat = r_acc[FS_W-1:0];
        end else begin
            w_fs_sat = r_acc[ACC_W-1] ? {1'b1, {(FS_W-1){1'b0}}} : {1'b0, {(FS_W-1){1'b1}}};
        end
    end

    // control value, truncated toward zero
    always_comb begin
        w_total = r_cross ? '0 : r_acc;
        w_round = w_total + {{(ACC_W-32){1'b0}}, {32{w_total[ACC_W-1]}}};
        w_c     = $signed(w_round[ACC_W-1:32]);
    end

    // drive fitting
    always_comb begin
        w_max   = (r_l > r_r) ? r_l : r_r;
        w_ex_hi = w_max - DRV_HI;
        w_min   = (r_l < r_r) ? r_l : r_r;
        w_ex_lo = DRV_LO - w_min;
        w_l2    = r_l;
        w_r2    = r_r;
        if (!w_ex_lo[DRV_W-1] && (w_ex_lo != '0)) begin
            w_l2 = r_l + w_ex_lo;
            w_r2 = r_r + w_ex_lo;
        end
        if (w_l2 > DRV_HI) begin
            w_lc = DRV_HI;
        end else if (w_l2 < DRV_LO) begin
            w_lc = DRV_LO;
        end else begin
            w_lc = w_l2;
        end
        if (w_r2 > DRV_HI) begin
            w_rc = DRV_HI;
        end else if (w_r2 < DRV_LO) begin
            w_rc = DRV_LO;
        end else begin
            w_rc = w_r2;
        end
    end

    // lost-line timing
    always_comb begin
        w_since   = r_lost ? r_since : r_time;
        w_elapsed = r_time - w_since;
        w_over    = w_elapsed > TIME_W'(r_tmo);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            if (w_dp == DP_LOAD) begin
                r_e     <= w_e_in;
                r_d     <= DIFF_W'(w_e_in) - DIFF_W'(r_prev);
                r_cross <= (w_cnt >= CNT_W'(CROSS_COUNT));
                r_time  <= i_time_ms;
            end
            if (w_dp == DP_INTEG) begin
                r_base <= base_for_error(r_base_speed, r_e);
            end
            if (w_dp == DP_CTRL) begin
                r_l <= DRV_W'($signed({1'b0, r_base})) + DRV_W'(w_c) + DRV_W'(r_ltrim);
                r_r <= DRV_W'($signed({1'b0, r_base})) - DRV_W'(w_c) + DRV_W'(r_rtrim);
            end
            if ((w_dp == DP_FIT_HI) && !w_ex_hi[DRV_W-1] && (w_ex_hi != '0)) begin
                r_l <= r_l - w_ex_hi;
                r_r <= r_r - w_ex_hi;
            end
        end
    end

    // controller state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_sum   <= '0;
            r_fs    <= '0;
            r_turn  <= 1'b0;
            r_lost  <= 1'b0;
            r_since <= '0;
        end else if (w_go) begin
            if (w_dp == DP_INTEG) begin
                r_sum  <= w_sum_new;
                r_prev <= r_e;
            end
            if (w_dp == DP_FS_SAVE) begin
                r_fs <= w_fs_sat;
            end
            if (w_dp == DP_CTRL) begin
                r_turn <= !w_total[ACC_W-1] && (w_total != '0);
            end
            if (w_dp == DP_EMIT) begin
                r_lost <= 1'b0;
            end
            if (w_dp == DP_LOST) begin
                r_lost  <= 1'b1;
                r_since <= w_since;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && ((w_dp == DP_EMIT) || (w_dp == DP_LOST))) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && (w_dp == DP_EMIT)) begin
            r_left  <= w_lc[DRV_OUT_W-1:0];
            r_right <= w_rc[DRV_OUT_W-1:0];
            r_mode  <= MODE_FOLLOW;
        end else if (w_go && (w_dp == DP_LOST)) begin
            if (w_over) begin
                r_left  <= '0;
                r_right <= '0;
                r_mode  <= MODE_STOP;
            end else begin
                r_left  <= r_turn ? SPIN_POS : SPIN_NEG;
                r_right <= r_turn ? SPIN_NEG : SPIN_POS;
                r_mode  <= MODE_SPIN;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;
    assign o_drive_mode  = r_mode;
    assign o_crossing    = 1'b0;

endmodule

// File: design/lfpd_checker.sv
`include "line_follower_pid_drive_core_macros.svh"

module lfpd_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [lfpd_pkg::DRV_OUT_W-1:0] o_left_speed,
    input logic signed [lfpd_pkg::DRV_OUT_W-1:0] o_right_speed,
    input logic [lfpd_pkg::MODE_W-1:0]           o_drive_mode
);
    import lfpd_pkg::*;

    // output word holds while stalled
    `LFPD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_speed) && $stable(o_right_speed) && $stable(o_drive_mode), "output word changed while stalled")

    // stopped means both drives off
    `LFPD_ASSERT(a_stop_zero, i_clk, i_rst_n, o_out_valid && (o_drive_mode == MODE_STOP) |-> (o_left_speed == '0) && (o_right_speed == '0), "stopped word with nonzero drive")

    // spin search drives opposite at spin speed
    `LFPD_ASSERT(a_spin_pair, i_clk, i_rst_n, o_out_valid && (o_drive_mode == MODE_SPIN) |-> ((o_left_speed == 9'sd140) && (o_right_speed == -9'sd140)) || ((o_left_speed == -9'sd140) && (o_right_speed == 9'sd140)), "spin word with wrong drive pair")

    // following drives stay inside the drive window
    `LFPD_ASSERT(a_follow_range, i_clk, i_rst_n, o_out_valid && (o_drive_mode == MODE_FOLLOW) |-> (o_left_speed >= -9'sd130) && (o_right_speed >= -9'sd130), "follow drive below window")

    // nothing pending after reset
    `LFPD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid right after reset")

endmodule

bind line_follower_pid_drive_core lfpd_checker u_lfpd_checker (.*);
